// ===== rtl/core/aktsp_pkg.sv =====
// Shared types and constants of the aging keyed table unit.
package aktsp_pkg;

  localparam int unsigned MaxEntriesDefault = 32;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRecordInvalid = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEntryLife     = 2'd1;

  localparam logic [31:0] RecordInvalidReset = 32'd0;
  localparam logic [31:0] EntryLifeReset     = 32'd30000;

  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic [7:0]  sat_key;
    logic [15:0] source_id;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        table_full;
    logic [5:0]  entry_count;
    logic        record_valid;
    logic [15:0] record_source;
    logic        source_known;
  } out_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] stamp;
  } entry_t;

endpackage

// ===== rtl/core/aktsp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module aktsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/aktsp_addcmp.sv =====
// Shared 32-bit wrapping add and compare against the current time.
module aktsp_addcmp (
  input  logic [31:0] base_i,
  input  logic [31:0] span_i,
  input  logic [31:0] now_i,
  output logic        ge_o
);

  logic [31:0] sum;

  assign sum  = base_i + span_i;
  assign ge_o = (sum >= now_i);

endmodule

// ===== rtl/core/aging_keyed_table_with_source_priority_unit.sv =====
// Top level: aging keyed satellite table with source priority.
//
// Pulse start while busy is low to hand in one item; the result appears on
// result_o for exactly one cycle, marked by result_valid_o, and must be taken
// then. An update or a query keeps busy high through the record validity check
// (StCheck), the table scan (StScan, one slot per cycle through the entry RAM's
// registered read port and the single add/compare unit), and the insert and
// result build (StDone). A rejected update skips the scan and goes straight
// from the check to StDone. The result strobe comes in the cycle in which busy
// falls, and the next item can be started in that same cycle. Configuration
// writes are always ready and must only be issued while no item is in flight.
module aging_keyed_table_with_source_priority_unit import aktsp_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_t                item_i,
  output logic               result_valid_o,
  output out_t               result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StScan  = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] rec_inv_q, entry_life_q;
  logic        rec_set_q, rec_set_d;
  logic [31:0] rec_time_q, rec_time_d;
  logic [15:0] last_src_q, last_src_d;

  in_t         item_q;
  logic        acc_q, acc_d;
  logic        found_q, found_d;
  logic        free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic        p_vld_q, p_vld_d;
  logic [IdxW-1:0] p_idx_q, p_idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [MaxEntries-1:0] used_q, used_d;

  out_t        result_q, result_d;
  logic        result_valid_q, result_valid_d;

  logic        ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t      ram_wdata, ram_rdata;

  logic [31:0] cmp_base, cmp_span;
  logic        cmp_ge;

  logic        slot_used, slot_match, slot_purge, slot_free;
  logic        rec_valid_now, do_insert, is_update;

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign is_update   = (item_q.cmd == CmdUpdate);

  aktsp_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Scan stage: slot p_idx_q, data from the read issued last cycle
  assign slot_used  = p_vld_q && used_q[p_idx_q];
  assign slot_match = slot_used && is_update && acc_q && !found_q &&
                      (ram_rdata.key == item_q.sat_key);
  assign slot_purge = slot_used && !cmp_ge;
  assign slot_free  = p_vld_q && (!used_q[p_idx_q] || slot_purge);

  // One add/compare unit: record age outside the scan, entry age during it (refreshed stamp on a key match)
  always_comb begin
    if (state_q == StScan) begin
      cmp_base = slot_match ? item_q.now_ms : ram_rdata.stamp;
      cmp_span = entry_life_q;
    end else begin
      cmp_base = rec_time_q;
      cmp_span = rec_inv_q;
    end
  end

  aktsp_addcmp u_addcmp (
    .base_i (cmp_base),
    .span_i (cmp_span),
    .now_i  (item_q.now_ms),
    .ge_o   (cmp_ge)
  );

  assign rec_valid_now = rec_set_q && ((rec_inv_q == 32'd0) || cmp_ge);
  assign do_insert     = is_update && acc_q && !found_q && free_found_q;

  always_comb begin
    state_d        = state_q;
    rec_set_d      = rec_set_q;
    rec_time_d     = rec_time_q;
    last_src_d     = last_src_q;
    acc_d          = acc_q;
    found_d        = found_q;
    free_found_d   = free_found_q;
    free_idx_d     = free_idx_q;
    rd_cnt_d       = rd_cnt_q;
    p_vld_d        = 1'b0;
    p_idx_d        = p_idx_q;
    count_d        = count_q;
    used_d         = used_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = p_idx_q;
    ram_wdata      = '{key: item_q.sat_key, stamp: item_q.now_ms};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        found_d      = 1'b0;
        free_found_d = 1'b0;
        rd_cnt_d     = '0;
        if (item_q.cmd == CmdQuery) begin
          acc_d   = 1'b0;
          state_d = StScan;
        end else if (rec_valid_now && (last_src_q < item_q.source_id)) begin
          acc_d   = 1'b0;
          state_d = StDone;
        end else begin
          acc_d      = 1'b1;
          rec_set_d  = 1'b1;
          rec_time_d = item_q.now_ms;
          last_src_d = item_q.source_id;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (rd_cnt_q != CntW'(MaxEntries)) begin
          p_vld_d  = 1'b1;
          p_idx_d  = rd_cnt_q[IdxW-1:0];
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end else begin
          state_d = StDone;
        end
        if (slot_match) begin
          found_d = 1'b1;
          ram_we  = 1'b1;
        end
        if (slot_purge) begin
          used_d[p_idx_q] = 1'b0;
          count_d         = count_q - CntW'(1);
        end
        if (slot_free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = p_idx_q;
        end
      end
      StDone: begin
        if (do_insert) begin
          ram_we             = 1'b1;
          ram_waddr          = free_idx_q;
          used_d[free_idx_q] = 1'b1;
          count_d            = count_q + CntW'(1);
        end
        result_d.accepted      = acc_q;
        result_d.table_full    = is_update && acc_q && !found_q && !free_found_q;
        result_d.entry_count   = 6'(count_d);
        result_d.record_valid  = rec_valid_now;
        result_d.record_source = last_src_q;
        result_d.source_known  = rec_set_q;
        result_valid_d         = 1'b1;
        state_d                = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      rec_inv_q      <= RecordInvalidReset;
      entry_life_q   <= EntryLifeReset;
      rec_set_q      <= 1'b0;
      rec_time_q     <= '0;
      last_src_q     <= '0;
      acc_q          <= 1'b0;
      found_q        <= 1'b0;
      free_found_q   <= 1'b0;
      rd_cnt_q       <= '0;
      p_vld_q        <= 1'b0;
      count_q        <= '0;
      used_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      rec_set_q      <= rec_set_d;
      rec_time_q     <= rec_time_d;
      last_src_q     <= last_src_d;
      acc_q          <= acc_d;
      found_q        <= found_d;
      free_found_q   <= free_found_d;
      rd_cnt_q       <= rd_cnt_d;
      p_vld_q        <= p_vld_d;
      count_q        <= count_d;
      used_q         <= used_d;
      result_valid_q <= result_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgRecordInvalid: rec_inv_q    <= cfg_data_i;
          CfgEntryLife:     entry_life_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
    free_idx_q <= free_idx_d;
    p_idx_q    <= p_idx_d;
    result_q   <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
